FILE: rtl/psw_pkg.sv
package psw_pkg;

   localparam int CHANNELS = 7;
   localparam int CH_BITS = 3;
   localparam int CFG_BITS = 7;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd8;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/psw_div.sv
module psw_div #(
   parameter int DIVIDEND_BITS = 38,
   parameter int DIVISOR_BITS = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DIVIDEND_BITS-1:0] dividend,
   input  logic        [DIVISOR_BITS-1:0]  divisor,
   output logic signed [DIVIDEND_BITS-1:0] quotient,
   output psw_pkg::div_status_type         status
);
   import psw_pkg::*;

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);
   localparam int PART_BITS = DIVISOR_BITS + 1;

   logic                     active_ff;
   logic                     done_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic                     neg_ff;
   logic [DIVIDEND_BITS-1:0] dq_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  divisor_ff;
   logic [DIVIDEND_BITS-1:0] quotient_ff;

   logic [DIVIDEND_BITS-1:0] magnitude;
   logic [PART_BITS-1:0]     part;
   logic [PART_BITS-1:0]     part_less;
   logic                     fits;
   logic [DIVISOR_BITS-1:0]  rem_in;

   // restoring division on the magnitude, one quotient bit a cycle
   always_comb begin
      magnitude = dividend[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend) : DIVIDEND_BITS'(dividend);
      part      = {rem_ff, dq_ff[DIVIDEND_BITS-1]};
      fits      = (part >= {1'b0, divisor_ff});
      part_less = part - {1'b0, divisor_ff};
      rem_in    = fits ? part_less[DIVISOR_BITS-1:0] : part[DIVISOR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            step_ff   <= STEP_BITS'(DIVIDEND_BITS);
         end else if (active_ff) begin
            if (step_ff == '0) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               step_ff <= step_ff - STEP_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff      <= magnitude;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         neg_ff     <= dividend[DIVIDEND_BITS-1];
      end else if (active_ff && step_ff != '0) begin
         dq_ff  <= {dq_ff[DIVIDEND_BITS-2:0], fits};
         rem_ff <= rem_in;
      end
      if (active_ff && step_ff == '0) begin
         quotient_ff <= neg_ff ? -dq_ff : dq_ff;
      end
   end

   assign quotient    = quotient_ff;
   assign status.busy = active_ff;
   assign status.done = done_ff;

   assert property (@(posedge clock) disable iff (reset) active_ff |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !active_ff)
      else $error("done while still dividing");
   assert property (@(posedge clock) disable iff (reset)
      active_ff && step_ff == '0 |=> done_ff)
      else $error("last step not followed by done");

endmodule

FILE: rtl/pose_sliding_window_average.sv
// Moving average over pose samples. Each accepted sample (three position and four quaternion
// components, signed Q16.16) enters a ring of the last window_length samples, and one result
// follows with the per-component mean of the samples held, truncated toward zero, plus the
// number of samples in that mean (fewer than the window while it fills). A window register of
// zero acts as one and values above MAX_WINDOW act as MAX_WINDOW; writing the register empties
// the window. After a transfer the seven running sums are updated one per cycle, then one
// bit-serial divider shared by all channels produces one quotient bit per cycle. One item is
// in work at a time; a finished result waits in its output register while the next sample
// is taken in.
module pose_sliding_window_average #(
   parameter int MAX_WINDOW = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_x,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_y,
   input  logic signed [SAMPLE_BITS-1:0]    req_pos_z,
   input  logic signed [SAMPLE_BITS-1:0]    req_quat_x,
   input  logic signed [SAMPLE_BITS-1:0]    req_quat_y,
   input  logic signed [SAMPLE_BITS-1:0]    req_quat_z,
   input  logic signed [SAMPLE_BITS-1:0]    req_quat_w,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_pos_x,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_pos_y,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_pos_z,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_quat_x,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_quat_y,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_quat_z,
   output logic signed [SAMPLE_BITS-1:0]    rsp_mean_quat_w,
   output logic [psw_pkg::CFG_BITS-1:0]     rsp_samples_held,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psw_pkg::CFG_BITS-1:0]     csr_window_length
);
   import psw_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int POS_BITS = CNT_BITS + 1;
   localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int ROW_BITS = CHANNELS * SAMPLE_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_DIV_START,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   state_type                   state_ff;
   logic [CH_BITS-1:0]          ch_ff;
   logic [CFG_BITS-1:0]         window_ff;
   logic [CNT_BITS-1:0]         fill_ff;
   logic [SLOT_BITS-1:0]        oldest_ff;
   logic signed [SUM_BITS-1:0]  sum_ff [CHANNELS];
   logic                        rsp_valid_ff;

   logic [SLOT_BITS-1:0]        slot_ff;
   logic                        evict_ff;
   logic [ROW_BITS-1:0]         sample_ff;
   logic [ROW_BITS-1:0]         old_ff;
   logic [ROW_BITS-1:0]         mean_ff;
   logic [ROW_BITS-1:0]         out_ff;
   logic [CFG_BITS-1:0]         held_ff;
   logic [ROW_BITS-1:0]         hist_mem [MAX_WINDOW];

   logic [CMP_BITS-1:0]         win_ext;
   logic [CNT_BITS-1:0]         w_eff;
   logic                        full;
   logic [POS_BITS-1:0]         pos;
   logic [POS_BITS-1:0]         oldest_step;
   logic [SLOT_BITS-1:0]        slot_in;
   logic [SLOT_BITS-1:0]        oldest_in;
   logic [CNT_BITS-1:0]         fill_in;
   logic signed [SAMPLE_BITS-1:0] new_word;
   logic signed [SAMPLE_BITS-1:0] sub_word;
   logic signed [SUM_BITS-1:0]  sum_in;
   logic                        accept;
   logic                        csr_we;
   logic                        emit_load;
   logic                        div_start;
   logic signed [SUM_BITS-1:0]  div_quotient;
   div_status_type              div_status;

   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_we    = csr_valid && csr_ready;
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign div_start = (state_ff == S_DIV_START);

   // window clamp and ring slot for the incoming sample
   always_comb begin
      win_ext = CMP_BITS'(window_ff);
      if (window_ff == '0) begin
         w_eff = CNT_BITS'(1);
      end else if (win_ext > CMP_BITS'(MAX_WINDOW)) begin
         w_eff = CNT_BITS'(MAX_WINDOW);
      end else begin
         w_eff = CNT_BITS'(win_ext);
      end
      full        = (fill_ff >= w_eff);
      pos         = POS_BITS'(oldest_ff) + POS_BITS'(fill_ff);
      oldest_step = POS_BITS'(oldest_ff) + POS_BITS'(1);
      if (full) begin
         slot_in   = oldest_ff;
         oldest_in = (oldest_step >= POS_BITS'(w_eff)) ? '0 : SLOT_BITS'(oldest_step);
         fill_in   = fill_ff;
      end else begin
         if (pos >= POS_BITS'(w_eff)) begin
            slot_in = SLOT_BITS'(pos - POS_BITS'(w_eff));
         end else begin
            slot_in = SLOT_BITS'(pos);
         end
         oldest_in = oldest_ff;
         fill_in   = fill_ff + CNT_BITS'(1);
      end
   end

   // running sum update, one channel a cycle
   always_comb begin
      new_word = sample_ff[SAMPLE_BITS-1:0];
      sub_word = evict_ff ? old_ff[SAMPLE_BITS-1:0] : '0;
      sum_in   = sum_ff[0] + SUM_BITS'(new_word) - SUM_BITS'(sub_word);
   end

   psw_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (CNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[0]),
      .divisor  (fill_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         window_ff    <= WINDOW_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (csr_we) begin
                  window_ff <= csr_window_length;
                  fill_ff   <= '0;
                  oldest_ff <= '0;
                  for (int k = 0; k < CHANNELS; k++) begin
                     sum_ff[k] <= '0;
                  end
               end else if (accept) begin
                  fill_ff   <= fill_in;
                  oldest_ff <= oldest_in;
                  ch_ff     <= '0;
                  state_ff  <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               for (int k = 0; k < CHANNELS - 1; k++) begin
                  sum_ff[k] <= sum_ff[k+1];
               end
               sum_ff[CHANNELS-1] <= sum_in;
               if (ch_ff == CH_BITS'(CHANNELS - 1)) begin
                  ch_ff    <= '0;
                  state_ff <= S_DIV_START;
               end else begin
                  ch_ff <= ch_ff + CH_BITS'(1);
               end
            end
            S_DIV_START: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_status.done) begin
                  for (int k = 0; k < CHANNELS - 1; k++) begin
                     sum_ff[k] <= sum_ff[k+1];
                  end
                  sum_ff[CHANNELS-1] <= sum_ff[0];
                  if (ch_ff == CH_BITS'(CHANNELS - 1)) begin
                     ch_ff    <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     ch_ff    <= ch_ff + CH_BITS'(1);
                     state_ff <= S_DIV_START;
                  end
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= {req_quat_w, req_quat_z, req_quat_y, req_quat_x,
                       req_pos_z, req_pos_y, req_pos_x};
         slot_ff   <= slot_in;
         evict_ff  <= full;
      end else if (state_ff == S_UPDATE) begin
         sample_ff <= sample_ff >> SAMPLE_BITS;
      end
      if (state_ff == S_DIV_WAIT && div_status.done) begin
         mean_ff <= {div_quotient[SAMPLE_BITS-1:0], mean_ff[ROW_BITS-1:SAMPLE_BITS]};
      end
      if (emit_load) begin
         out_ff  <= mean_ff;
         held_ff <= CFG_BITS'(fill_ff);
      end
   end

   // sample history: read of the evicted row on transfer, write of the new row after it
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff <= hist_mem[slot_in];
      end else if (state_ff == S_UPDATE) begin
         old_ff <= old_ff >> SAMPLE_BITS;
      end
      if (state_ff == S_UPDATE && ch_ff == '0) begin
         hist_mem[slot_ff] <= sample_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_pos_x   = out_ff[0*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_pos_y   = out_ff[1*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_pos_z   = out_ff[2*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_quat_x  = out_ff[3*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_quat_y  = out_ff[4*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_quat_z  = out_ff[5*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_mean_quat_w  = out_ff[6*SAMPLE_BITS +: SAMPLE_BITS];
   assign rsp_samples_held = held_ff;

   assert property (@(posedge clock) disable iff (reset) fill_ff <= w_eff)
      else $error("fill count beyond window");
   assert property (@(posedge clock) disable iff (reset) oldest_ff != '0 |-> fill_ff == w_eff)
      else $error("ring advanced before window filled");
   assert property (@(posedge clock) disable iff (reset) div_start |-> fill_ff != '0)
      else $error("divider started with zero count");
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV_WAIT)
      else $error("divider result outside wait state");

endmodule

FILE: tb/tb_pose_sliding_window_average.sv
`timescale 1ns / 1ps

module tb_pose_sliding_window_average;
   import psw_pkg::*;

   localparam int MAX_WINDOW = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int TOTAL_POSES = 750;
   localparam int SETTLE_CYCLES = 320;
   localparam int PRINT_LIMIT = 100;

   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] pose_type;

   typedef struct packed {
      pose_type            mean;
      logic [CFG_BITS-1:0] held;
   } mean_rec_type;

   class pose_mean_board;
      logic [CFG_BITS-1:0] window_reg;
      int                  hist [CHANNELS][MAX_WINDOW];
      longint              sums [CHANNELS];
      int                  fill;
      int                  oldest;
      mean_rec_type        pending_means [$];
      int                  errors;

      function new();
         errors = 0;
         set_window(WINDOW_RESET);
      endfunction

      function void set_window(input logic [CFG_BITS-1:0] w);
         window_reg = w;
         foreach (sums[c]) sums[c] = 0;
         fill = 0;
         oldest = 0;
      endfunction

      function void report(input string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      function void stash_mean(input mean_rec_type r);
         pending_means.insert(pending_means.size(), r);
      endfunction

      function mean_rec_type take_mean();
         mean_rec_type r;
         r = pending_means[0];
         pending_means.delete(0);
         return r;
      endfunction

      // new sample enters the ring, then the mean of what is held is queued
      function void note_pose(input pose_type p);
         int           w;
         int           slot;
         longint       q;
         mean_rec_type r;
         w = int'(window_reg);
         if (w < 1) w = 1;
         if (w > MAX_WINDOW) w = MAX_WINDOW;
         if (fill < w) begin
            slot = oldest + fill;
            if (slot >= w) slot -= w;
            fill++;
         end else begin
            slot = oldest;
            oldest = (oldest + 1 >= w) ? 0 : oldest + 1;
            for (int c = 0; c < CHANNELS; c++) sums[c] -= longint'(hist[c][slot]);
         end
         for (int c = 0; c < CHANNELS; c++) begin
            hist[c][slot] = $signed(p[c]);
            sums[c] += longint'(hist[c][slot]);
         end
         for (int c = 0; c < CHANNELS; c++) begin
            q = sums[c] / longint'(fill);
            r.mean[c] = q[SAMPLE_BITS-1:0];
         end
         r.held = fill[CFG_BITS-1:0];
         stash_mean(r);
      endfunction

      function void check_mean(input mean_rec_type got);
         mean_rec_type want;
         if (pending_means.size() == 0) begin
            report($sformatf("result with none pending, samples_held %0d", got.held));
            return;
         end
         want = take_mean();
         for (int c = 0; c < CHANNELS; c++) begin
            if (got.mean[c] !== want.mean[c])
               report($sformatf("component %0d: got %0d, expected %0d", c,
                  $signed(got.mean[c]), $signed(want.mean[c])));
         end
         if (got.held !== want.held)
            report($sformatf("samples_held: got %0d, expected %0d", got.held, want.held));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [SAMPLE_BITS-1:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_pos_x, rsp_mean_pos_y, rsp_mean_pos_z;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_quat_x, rsp_mean_quat_y;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_quat_z, rsp_mean_quat_w;
   logic [CFG_BITS-1:0]           rsp_samples_held;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CFG_BITS-1:0]           csr_window_length;

   pose_mean_board board;
   bit             calm;
   int             sent;

   pose_sliding_window_average #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .req_quat_w        (req_quat_w),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mean_pos_x    (rsp_mean_pos_x),
      .rsp_mean_pos_y    (rsp_mean_pos_y),
      .rsp_mean_pos_z    (rsp_mean_pos_z),
      .rsp_mean_quat_x   (rsp_mean_quat_x),
      .rsp_mean_quat_y   (rsp_mean_quat_y),
      .rsp_mean_quat_z   (rsp_mean_quat_z),
      .rsp_mean_quat_w   (rsp_mean_quat_w),
      .rsp_samples_held  (rsp_samples_held),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pause_len();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_component();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return '0;
               3: return '1;
               default: return 32'd1;
            endcase
         end
         1, 2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      for (int c = 0; c < CHANNELS; c++) p[c] = pick_component();
      return p;
   endfunction

   function automatic pose_type flat_pose(input logic [SAMPLE_BITS-1:0] v);
      pose_type p;
      for (int c = 0; c < CHANNELS; c++) p[c] = v;
      return p;
   endfunction

   task automatic wait_idle();
      while (board.pending_means.size() != 0) @(posedge clock);
   endtask

   task automatic send_pose(input pose_type p);
      int gap;
      bit settle;
      gap = pause_len();
      settle = ($urandom_range(0, 59) == 0);
      if (gap > 0 || settle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         if (settle) wait_idle();
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_pos_x  <= p[0];
      req_pos_y  <= p[1];
      req_pos_z  <= p[2];
      req_quat_x <= p[3];
      req_quat_y <= p[4];
      req_quat_z <= p[5];
      req_quat_w <= p[6];
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_pose(p);
      sent++;
   endtask

   task automatic close_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      wait_idle();
   endtask

   task automatic write_window(input logic [CFG_BITS-1:0] w);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_window_length <= w;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_window(w);
      csr_valid <= 1'b0;
   endtask

   initial begin : result_side
      int           n;
      mean_rec_type got;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         n = pause_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.mean[0] = rsp_mean_pos_x;
         got.mean[1] = rsp_mean_pos_y;
         got.mean[2] = rsp_mean_pos_z;
         got.mean[3] = rsp_mean_quat_x;
         got.mean[4] = rsp_mean_quat_y;
         got.mean[5] = rsp_mean_quat_z;
         got.mean[6] = rsp_mean_quat_w;
         got.held = rsp_samples_held;
         board.check_mean(got);
      end
   end

   initial begin : stimulus
      pose_type mixed;
      int       phase_len;
      board = new();
      calm = 1'b0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_quat_x = '0;
      req_quat_y = '0;
      req_quat_z = '0;
      req_quat_w = '0;
      csr_valid = 1'b0;
      csr_window_length = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default window: filling, truncation toward zero, then eviction
      mixed[0] = 32'h7fff_ffff;
      mixed[1] = 32'h8000_0000;
      mixed[2] = 32'h0000_0000;
      mixed[3] = 32'hffff_ffff;
      mixed[4] = 32'h0000_0001;
      mixed[5] = 32'h0001_0000;
      mixed[6] = 32'hffff_0000;
      send_pose(flat_pose(32'h7fff_ffff));
      send_pose(flat_pose(32'h8000_0000));
      send_pose(flat_pose(32'hffff_fffd));
      send_pose(flat_pose(32'h0000_0000));
      send_pose(flat_pose(32'h0000_0001));
      send_pose(flat_pose(32'hffff_ffff));
      send_pose(mixed);
      send_pose(flat_pose(32'h8000_0000));
      send_pose(flat_pose(32'h8000_0000));
      send_pose(flat_pose(32'h7fff_ffff));
      send_pose(random_pose());
      send_pose(random_pose());

      // zero window acts as one
      close_phase();
      write_window(7'd0);
      send_pose(flat_pose(32'h8000_0000));
      send_pose(flat_pose(32'h7fff_ffff));
      send_pose(random_pose());

      // oversized window saturates, full-scale sums
      close_phase();
      write_window(7'd127);
      calm = 1'b1;
      repeat (66) send_pose(flat_pose(32'h8000_0000));
      calm = 1'b0;
      repeat (66) send_pose(flat_pose(32'h7fff_ffff));

      close_phase();
      write_window(7'd1);
      repeat (20) send_pose(random_pose());

      while (sent < TOTAL_POSES) begin
         close_phase();
         case ($urandom_range(0, 7))
            0: write_window(7'd1);
            1: write_window(7'd64);
            2: write_window(7'd0);
            3: write_window(CFG_BITS'($urandom_range(65, 127)));
            default: write_window(CFG_BITS'($urandom_range(2, 63)));
         endcase
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(10, 120);
         repeat (phase_len) send_pose(random_pose());
      end

      close_phase();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_means.size() == 0) begin
         $display("pose_sliding_window_average verification clean");
      end else begin
         $display("pose_sliding_window_average verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("pose_sliding_window_average verification failed");
      $finish;
   end

endmodule

FILE: pose_sliding_window_average.f
rtl/psw_pkg.sv
rtl/psw_div.sv
rtl/pose_sliding_window_average.sv
tb/tb_pose_sliding_window_average.sv
